FILE: sv/bc6h_pkg.sv
// Package for the BC6H single-region tile encoder.
// Widths, phase enum and small helpers; no dependencies.
package bc6h_pkg;
  localparam int TilePixels = 16;
  localparam int IdxW = $clog2(TilePixels);
  localparam int ChanW = 17;
  localparam int LumaW = 18;
  localparam logic [4:0] ModeBits = 5'd3;

  typedef enum logic [2:0] {
    ST_LOAD, ST_DIV, ST_IDX, ST_OUT0, ST_OUT1
  } state_t;

  function automatic logic [9:0] quant10(input logic [ChanW-1:0] v);
    logic [ChanW:0] s;
    s = {1'b0, v} + (ChanW+1)'(32);
    if (s[ChanW:6] > 12'd1023) return 10'd1023;
    return s[15:6];
  endfunction
endpackage

FILE: sv/bc6h_single_region_block_encoder.sv
// BC6H mode-11 single-region encoder, top level.
// Depends on bc6h_pkg.
// Pixels are taken one per cycle while busy is low. After pixel 16
// busy stays high through a 16-step restoring divide, then index
// mapping (16 luma store reads from a registered RAM), then two output words on
// consecutive cycles, lower word first; the receiver cannot stall them.
// Reset (rst_n low, synchronous) clears the pixel count, bounds and config.
module bc6h_single_region_block_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  output logic        out_strobe,
  output logic [63:0] out_block_word,
  output logic        out_last_word
);
  import bc6h_pkg::*;

  state_t st_r, st_nxt;
  logic cfg_r;
  logic [IdxW:0] cnt_r;
  logic [LumaW-1:0] min_r, max_r;
  logic [3*ChanW-1:0] lo_r, hi_r;
  logic swap_r;
  logic [LumaW-1:0] mid_r;
  // luma of pixel 0, kept for the swap decision
  logic [LumaW-2:0] luma0_r;
  // divider
  logic [LumaW-1:0] den_r, rem_r;
  logic [15:0] quo_r;
  logic [4:0] dstep_r;
  // index phase
  logic [IdxW:0] icnt_r;
  logic rd_vld_r;
  logic [IdxW-1:0] rd_idx_r;
  logic [62:0] idxbits_r;

  // luma memory
  logic [LumaW-2:0] luma_mem [TilePixels];
  logic [LumaW-2:0] rd_data_r;
  logic mem_we;
  logic [IdxW-1:0] mem_wa, mem_ra;
  logic [LumaW-2:0] mem_wd;

  logic accept;
  logic [ChanW-1:0] cr, cg, cb;
  logic [LumaW-1:0] y;
  logic first;

  assign accept = start && !busy;
  assign busy = (st_r != ST_LOAD);
  assign cr = cfg_r ? {in_red, 1'b0} : {1'b0, in_red};
  assign cg = cfg_r ? {in_green, 1'b0} : {1'b0, in_green};
  assign cb = cfg_r ? {in_blue, 1'b0} : {1'b0, in_blue};
  assign y = LumaW'(({2'b0, cr} + {1'b0, cg, 1'b0} + {2'b0, cb}) >> 2);
  assign first = (cnt_r == '0);

  assign mem_we = accept;
  assign mem_wa = cnt_r[IdxW-1:0];
  assign mem_wd = y[LumaW-2:0];
  assign mem_ra = icnt_r[IdxW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) luma_mem[mem_wa] <= mem_wd;
    rd_data_r <= luma_mem[mem_ra];
  end

  // mid and swap from final bounds (combinational on the last pixel)
  logic [LumaW-1:0] fmin, fmax;
  logic [LumaW:0] msum;
  logic [LumaW-1:0] fmid;
  assign fmin = (first || y < min_r) ? y : min_r;
  assign fmax = (first || y > max_r) ? y : max_r;
  assign msum = {1'b0, fmin} + {1'b0, fmax};
  assign fmid = msum[LumaW:1];

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_LOAD: if (accept && cnt_r == (IdxW+1)'(TilePixels-1)) st_nxt = ST_DIV;
      ST_DIV:  if (dstep_r == 5'd15) st_nxt = ST_IDX;
      ST_IDX:  if (rd_vld_r && rd_idx_r == IdxW'(TilePixels-1)) st_nxt = ST_OUT0;
      ST_OUT0: st_nxt = ST_OUT1;
      ST_OUT1: st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_LOAD;
    else st_r <= st_nxt;
  end

  // index math on the registered read
  logic [LumaW-1:0] yr;
  logic signed [LumaW+1:0] dy;
  logic signed [LumaW+18:0] t;
  logic signed [LumaW+18:0] xs;
  logic [3:0] ix;
  always_comb begin
    yr = swap_r ? LumaW'(({1'b0, min_r} + {1'b0, max_r}) - {2'b0, rd_data_r})
                : {1'b0, rd_data_r};
    dy = $signed({2'b0, yr}) - $signed({2'b0, mid_r});
    t = (LumaW+19)'(dy) * $signed({3'b0, quo_r}) + (LumaW+19)'(65536);
    xs = (t >>> 12) - (LumaW+19)'(8);
    if (t < 0 || xs < 0) ix = 4'd0;
    else if (xs > 15) ix = 4'd15;
    else ix = xs[3:0];
  end

  logic [LumaW:0] rsh;
  assign rsh = {rem_r, quo_r[15]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 1'b0;
      cnt_r <= '0;
      min_r <= '1;
      max_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
      rd_vld_r <= 1'b0;
      icnt_r <= '0;
      dstep_r <= '0;
    end else begin
      if (cfg_we) cfg_r <= cfg_wdata;
      rd_vld_r <= 1'b0;
      case (st_r)
        ST_LOAD: if (accept) begin
          cnt_r <= cnt_r + 1'b1;
          min_r <= fmin;
          max_r <= fmax;
          if (first) luma0_r <= y[LumaW-2:0];
          if (first || y < min_r) lo_r <= {cb, cg, cr};
          if (first || y > max_r) hi_r <= {cb, cg, cr};
          if (cnt_r == (IdxW+1)'(TilePixels-1)) begin
            mid_r <= fmid;
            swap_r <= ({1'b0, luma0_r} >= fmid);
            den_r <= fmax - fmid + 1'b1;
            rem_r <= '0;
            quo_r <= 16'h8000;
            dstep_r <= '0;
            icnt_r <= '0;
          end
        end
        ST_DIV: begin
          // restoring divide, 32768 / den, one quotient bit a cycle
          if (rsh >= {1'b0, den_r}) begin
            rem_r <= LumaW'(rsh - {1'b0, den_r});
            quo_r <= {quo_r[14:0], 1'b1};
          end else begin
            rem_r <= rsh[LumaW-1:0];
            quo_r <= {quo_r[14:0], 1'b0};
          end
          dstep_r <= dstep_r + 1'b1;
          if (dstep_r == 5'd15 && swap_r) begin
            lo_r <= hi_r;
            hi_r <= lo_r;
          end
        end
        ST_IDX: begin
          if (!icnt_r[IdxW]) begin
            rd_vld_r <= 1'b1;
            rd_idx_r <= icnt_r[IdxW-1:0];
            icnt_r <= icnt_r + 1'b1;
          end
          if (rd_vld_r) begin
            if (rd_idx_r == '0) idxbits_r <= {idxbits_r[62:3], (ix > 4'd7) ? 3'd7 : ix[2:0]};
            else idxbits_r[4*rd_idx_r-1 +: 4] <= ix;
          end
        end
        ST_OUT1: begin
          cnt_r <= '0;
          min_r <= '1;
          max_r <= '0;
        end
        default: ;
      endcase
    end
  end

  // block assembly
  logic [127:0] blk;
  assign blk = {idxbits_r,
                quant10(hi_r[3*ChanW-1:2*ChanW]), quant10(hi_r[2*ChanW-1:ChanW]),
                quant10(hi_r[ChanW-1:0]),
                quant10(lo_r[3*ChanW-1:2*ChanW]), quant10(lo_r[2*ChanW-1:ChanW]),
                quant10(lo_r[ChanW-1:0]), ModeBits};
  assign out_strobe = (st_r == ST_OUT0) || (st_r == ST_OUT1);
  assign out_last_word = (st_r == ST_OUT1);
  assign out_block_word = out_last_word ? blk[127:64] : blk[63:0];

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !accept) else $error("accept while busy");
  a_out_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT0) |=> out_strobe && out_last_word) else $error("missing upper word");
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_OUT1) |=> cnt_r == '0) else $error("count not cleared");
`endif
endmodule
